// ===== rtl/core/u8sd_pkg.sv =====
// shared constants, result types and error codes for the utf-8 stream decoder
// no dependencies

package u8sd_pkg;

    // longest sequence a lead byte may announce
    localparam logic [3:0] MAX_SEQ_BYTES = 4'd6;

    localparam int CP_W = 31;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 31'h0000_FFFD;
    localparam logic [CP_W-1:0] CP_QMARK       = 31'h0000_003F;
    localparam logic [CP_W-1:0] CP_NONCHAR_LO  = 31'h0000_FFFE;
    localparam logic [CP_W-1:0] CP_NONCHAR_HI  = 31'h0000_FFFF;

    // error kinds
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_STRAY_CONT = 3'd1;
    localparam logic [2:0] ERR_ILLEGAL    = 3'd2;
    localparam logic [2:0] ERR_INCOMPLETE = 3'd3;
    localparam logic [2:0] ERR_OVERLONG   = 3'd4;
    localparam logic [2:0] ERR_NONCHAR    = 3'd5;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [2:0]      error_kind;
        logic            last_of_run;
    } t_result;

    // everything one byte produces: zero, one or two results
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_step;

endpackage

// ===== rtl/core/u8sd_step.sv =====
// per-byte decode logic and sequence state (partial value, length, remaining)
// depends on u8sd_pkg

module u8sd_step
    import u8sd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_data_byte,
    input  logic       i_eos,
    input  logic       i_narrow,
    output t_step      o_step
);

    logic [CP_W-1:0] r_partial;
    logic [2:0]      r_remaining;
    logic [2:0]      r_length;
    logic [CP_W-1:0] n_partial;
    logic [2:0]      n_remaining;
    logic [2:0]      n_length;

    logic            pending;
    logic            is_cont;
    logic [3:0]      fresh_len;
    logic [CP_W-1:0] ext_value;
    logic [2:0]      rem_dec;
    logic            have_int;
    logic            x_vld;
    t_result         x_res;
    t_result         int_res;

    function automatic logic [3:0] lead_len(input logic [7:0] b);
        logic [3:0] n;
        case (b) inside
            8'b110?????: n = 4'd2;
            8'b1110????: n = 4'd3;
            8'b11110???: n = 4'd4;
            8'b111110??: n = 4'd5;
            8'b1111110?: n = 4'd6;
            8'b11111110: n = 4'd7;
            8'b11111111: n = 4'd8;
            default:     n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic t_result mk(input logic [CP_W-1:0] cp, input logic [2:0] err);
        t_result r;
        r.code_point  = cp;
        r.error_kind  = err;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // value at or above the smallest one its length may encode
    function automatic logic min_ok(input logic [CP_W-1:0] v, input logic [2:0] n);
        logic ok;
        case (n)
            3'd2:    ok = |v[CP_W-1:7];
            3'd3:    ok = |v[CP_W-1:11];
            3'd4:    ok = |v[CP_W-1:16];
            3'd5:    ok = |v[CP_W-1:21];
            3'd6:    ok = |v[CP_W-1:26];
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

    function automatic t_result finish(input logic [CP_W-1:0] v, input logic [2:0] n);
        t_result r;
        if (!min_ok(v, n)) begin
            // c0 80 is the one overlong form let through, as zero
            if (v == '0 && n == 3'd2) begin
                r = mk('0, ERR_NONE);
            end else begin
                r = mk(CP_REPLACEMENT, ERR_OVERLONG);
            end
        end else if (v == CP_NONCHAR_LO || v == CP_NONCHAR_HI) begin
            r = mk(v, ERR_NONCHAR);
        end else begin
            r = mk(v, ERR_NONE);
        end
        return r;
    endfunction

    function automatic t_result narrow(input t_result r, input logic en);
        t_result o;
        o = r;
        if (en && |r.code_point[CP_W-1:8]) begin
            o.code_point = CP_QMARK;
        end
        return o;
    endfunction

    assign pending   = (r_remaining != 3'd0);
    assign is_cont   = (i_data_byte[7:6] == 2'b10);
    assign fresh_len = lead_len(i_data_byte);
    assign ext_value = {r_partial[CP_W-7:0], i_data_byte[5:0]};
    assign rem_dec   = r_remaining - 3'd1;
    assign int_res   = mk(CP_REPLACEMENT, ERR_INCOMPLETE);

    always_comb begin
        n_partial   = r_partial;
        n_remaining = r_remaining;
        n_length    = r_length;
        have_int    = 1'b0;
        x_vld       = 1'b0;
        x_res       = mk('0, ERR_NONE);
        if (pending && is_cont) begin
            if (rem_dec == 3'd0) begin
                x_vld       = 1'b1;
                x_res       = finish(ext_value, r_length);
                n_partial   = '0;
                n_length    = 3'd0;
                n_remaining = 3'd0;
            end else if (i_eos) begin
                x_vld       = 1'b1;
                x_res       = mk(CP_REPLACEMENT, ERR_INCOMPLETE);
                n_partial   = '0;
                n_length    = 3'd0;
                n_remaining = 3'd0;
            end else begin
                n_partial   = ext_value;
                n_remaining = rem_dec;
            end
        end else begin
            // an interrupted sequence is reported first, then the byte starts afresh
            have_int    = pending;
            n_partial   = '0;
            n_length    = 3'd0;
            n_remaining = 3'd0;
            if (!i_data_byte[7]) begin
                x_vld = 1'b1;
                x_res = mk(CP_W'(i_data_byte), ERR_NONE);
            end else if (is_cont) begin
                x_vld = 1'b1;
                x_res = mk(CP_QMARK, ERR_STRAY_CONT);
            end else if (fresh_len > MAX_SEQ_BYTES) begin
                x_vld = 1'b1;
                x_res = mk(CP_REPLACEMENT, ERR_ILLEGAL);
            end else if (i_eos) begin
                // lead byte as the last byte of the string
                x_vld = 1'b1;
                x_res = mk(CP_REPLACEMENT, ERR_INCOMPLETE);
            end else begin
                n_partial   = CP_W'(i_data_byte & (8'h7F >> fresh_len));
                n_length    = fresh_len[2:0];
                n_remaining = fresh_len[2:0] - 3'd1;
            end
        end
    end

    always_comb begin
        o_step.count = {1'b0, have_int} + {1'b0, x_vld};
        o_step.res0  = narrow(have_int ? int_res : x_res, i_narrow);
        o_step.res1  = narrow(x_res, i_narrow);
        o_step.res0.last_of_run = !(have_int && x_vld);
        o_step.res1.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial   <= '0;
            r_remaining <= 3'd0;
            r_length    <= 3'd0;
        end else if (i_advance) begin
            r_partial   <= n_partial;
            r_remaining <= n_remaining;
            r_length    <= n_length;
        end
    end

endmodule

// ===== rtl/core/utf8_stream_decoder_unit.sv =====
// top level of the utf-8 stream decoder: input register, config register, result queue
// depends on u8sd_pkg and u8sd_step
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+------------------------------------------
//   input    | i_in_valid / o_in_ready     | i_data_byte, i_end_of_string
//   output   | o_out_valid / i_out_ready   | o_code_point, o_error_kind, o_last_of_run
//   config   | i_cfg_we (no wait)          | i_cfg_wdata (narrow output mode)
//
// one byte is taken per cycle while o_in_ready is high; an accepted byte waits in the
// input register until the queue has room, then its results are written into the queue
// a byte giving two results fills two queue entries, which are read out one at a time
// the input register moves into the decode only while the four-entry result queue has two
// free slots, so o_in_ready falls when the input register holds a byte and the queue holds
// three or more results
// synchronous active-low reset clears the sequence state, the queue and the mode register

module utf8_stream_decoder_unit
    import u8sd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_string,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [CP_W-1:0] o_code_point,
    output logic [2:0]      o_error_kind,
    output logic            o_last_of_run,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata
);

    // mode register
    logic r_narrow;

    // input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_eos;

    // result queue
    t_result          r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic       room;
    logic       advance;
    logic       in_accept;
    logic       pop;
    logic [1:0] push_cnt;
    t_step      step;

    // room for the worst case of two results, judged on the registered fill only
    assign room      = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign advance   = r_in_valid && room;
    assign o_in_ready = !r_in_valid || room;
    assign in_accept = i_in_valid && o_in_ready;

    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && i_out_ready;
    assign push_cnt    = advance ? step.count : 2'd0;

    assign o_code_point  = r_fifo[r_rd_ptr].code_point;
    assign o_error_kind  = r_fifo[r_rd_ptr].error_kind;
    assign o_last_of_run = r_fifo[r_rd_ptr].last_of_run;

    u8sd_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_data_byte (r_byte),
        .i_eos       (r_eos),
        .i_narrow    (r_narrow),
        .o_step      (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow <= 1'b0;
        end else if (i_cfg_we) begin
            r_narrow <= i_cfg_wdata;
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_byte <= i_data_byte;
            r_eos  <= i_end_of_string;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(push_cnt) - CNT_W'(pop);
        end
    end

    // queue entries: first result at the write pointer, second one after it
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= step.res0;
        end
        if (push_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= step.res1;
        end
    end

`ifndef NO_ASSERTIONS
    // the queue never overfills
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // a byte that produces results shows one at the output on the next cycle
    a_result_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && step.count != 2'd0) |=> o_out_valid)
        else $error("result lost after decode");

    // the input register only advances with queue room for both results
    a_two_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_count <= CNT_W'(FIFO_DEPTH)) && ($past(r_count) + CNT_W'(2)
            <= CNT_W'(FIFO_DEPTH)))
        else $error("decode advanced without room");
`endif

endmodule
